// ----- rtl/mssl_pkg.sv -----
// ----------------------------------------------------------------------------
// mssl_pkg
// Types and constants shared by the motor speed slew limiter.
// ----------------------------------------------------------------------------
package mssl_pkg;

  localparam int SpeedW   = 11;
  localparam int WideW    = 13;
  localparam int MagW     = 10;
  localparam int PctW     = 7;
  localparam int TimeW    = 32;
  localparam int IntervW  = 16;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  typedef logic signed [SpeedW-1:0] speed_t;
  typedef logic signed [WideW-1:0]  wide_t;
  typedef logic [MagW-1:0]          mag_t;
  typedef logic [PctW-1:0]          pct_t;
  typedef logic [TimeW-1:0]         time_t;
  typedef logic [IntervW-1:0]       interval_t;
  typedef logic [CfgIdxW-1:0]       cfg_idx_t;
  typedef logic [CfgDataW-1:0]      cfg_data_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_UPDATE_INTERVAL = 3'd0,
    REG_RAMP_STEP_LO    = 3'd1,
    REG_RAMP_STEP_FAST  = 3'd2,
    REG_DEFL_THRESHOLD  = 3'd3,
    REG_MIN_SPEED       = 3'd4,
    REG_SPEED_LIMIT     = 3'd5,
    REG_DEAD_BAND       = 3'd6,
    REG_BRAKE_THRESHOLD = 3'd7
  } reg_idx_t;

  typedef struct packed {
    interval_t update_interval;
    mag_t      ramp_step_lo;
    mag_t      ramp_step_fast;
    pct_t      deflection_threshold;
    mag_t      min_speed;
    mag_t      speed_limit;
    mag_t      dead_band;
    mag_t      brake_threshold;
  } cfg_t;

  typedef struct packed {
    speed_t current_speed;
    speed_t target_speed;
    pct_t   deflection_pct;
    time_t  now_ms;
  } item_t;

  localparam interval_t RstUpdateInterval = 16'd20;
  localparam mag_t      RstRampStepSlow   = 10'd5;
  localparam mag_t      RstRampStepFast   = 10'd15;
  localparam pct_t      RstDeflThreshold  = 7'd90;
  localparam mag_t      RstMinSpeed       = 10'd40;
  localparam mag_t      RstMaxSpeed       = 10'd255;
  localparam mag_t      RstMotorDeadzone  = 10'd10;
  localparam mag_t      RstBrakeThreshold = 10'd200;

endpackage

// ----- rtl/mssl_if.sv -----
// ----------------------------------------------------------------------------
// mssl channel interfaces
// Valid/ready channels for input items, results and register writes.
// ----------------------------------------------------------------------------
interface mssl_in_if;
  logic                  valid;
  logic                  ready;
  mssl_pkg::speed_t      current_speed;
  mssl_pkg::speed_t      target_speed;
  mssl_pkg::pct_t        deflection_pct;
  mssl_pkg::time_t       now_ms;

  modport source (output valid, current_speed, target_speed, deflection_pct, now_ms,
                  input ready);
  modport sink   (input valid, current_speed, target_speed, deflection_pct, now_ms,
                  output ready);
endinterface

interface mssl_out_if;
  logic                  valid;
  logic                  ready;
  mssl_pkg::speed_t      next_speed;
  logic                  held;

  modport source (output valid, next_speed, held, input ready);
  modport sink   (input valid, next_speed, held, output ready);
endinterface

interface mssl_cfg_if;
  logic                  valid;
  logic                  ready;
  mssl_pkg::cfg_idx_t    index;
  mssl_pkg::cfg_data_t   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/mssl_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// mssl_cfg_regs
// Configuration register file, written one register per transaction.
// ----------------------------------------------------------------------------
module mssl_cfg_regs (
  input  logic               clk,
  input  logic               rst,
  mssl_cfg_if.sink           cfg,
  output mssl_pkg::cfg_t     regs
);
  import mssl_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.update_interval      <= RstUpdateInterval;
      regs.ramp_step_lo         <= RstRampStepSlow;
      regs.ramp_step_fast       <= RstRampStepFast;
      regs.deflection_threshold <= RstDeflThreshold;
      regs.min_speed            <= RstMinSpeed;
      regs.speed_limit          <= RstMaxSpeed;
      regs.dead_band            <= RstMotorDeadzone;
      regs.brake_threshold      <= RstBrakeThreshold;
    end else if (cfg.valid && cfg.ready) begin
      unique case (reg_idx_t'(cfg.index))
        REG_UPDATE_INTERVAL: regs.update_interval      <= cfg.data;
        REG_RAMP_STEP_LO:    regs.ramp_step_lo         <= cfg.data[MagW-1:0];
        REG_RAMP_STEP_FAST:  regs.ramp_step_fast       <= cfg.data[MagW-1:0];
        REG_DEFL_THRESHOLD:  regs.deflection_threshold <= cfg.data[PctW-1:0];
        REG_MIN_SPEED:       regs.min_speed            <= cfg.data[MagW-1:0];
        REG_SPEED_LIMIT:     regs.speed_limit          <= cfg.data[MagW-1:0];
        REG_DEAD_BAND:       regs.dead_band            <= cfg.data[MagW-1:0];
        REG_BRAKE_THRESHOLD: regs.brake_threshold      <= cfg.data[MagW-1:0];
      endcase
    end
  end

endmodule

// ----- rtl/mssl_core.sv -----
// ----------------------------------------------------------------------------
// mssl_core
// Interval check, ramp step and shaping rules for one speed sample.
// ----------------------------------------------------------------------------
module mssl_core (
  input  mssl_pkg::cfg_t     regs,
  input  mssl_pkg::item_t    item,
  input  mssl_pkg::time_t    last_update_time,
  output mssl_pkg::speed_t   next_speed,
  output logic               held
);
  import mssl_pkg::*;

  time_t  elapsed;
  mag_t   step_sel;
  wide_t  c, t, s, mn, mx, dz, brk, acur, delta, nx, nx2, cl, res;
  logic   in_dz;

  assign elapsed = item.now_ms - last_update_time;
  assign held    = elapsed < {{(TimeW-IntervW){1'b0}}, regs.update_interval};

  always_comb begin
    step_sel = (item.deflection_pct >= regs.deflection_threshold) ? regs.ramp_step_fast
                                                                  : regs.ramp_step_lo;
    if (step_sel == '0) begin
      step_sel = mag_t'(1);
    end
    c    = wide_t'(item.current_speed);
    t    = wide_t'(item.target_speed);
    s    = $signed({{(WideW-MagW){1'b0}}, step_sel});
    mn   = $signed({{(WideW-MagW){1'b0}}, regs.min_speed});
    mx   = $signed({{(WideW-MagW){1'b0}}, regs.speed_limit});
    dz   = $signed({{(WideW-MagW){1'b0}}, regs.dead_band});
    brk  = $signed({{(WideW-MagW){1'b0}}, regs.brake_threshold});
    acur = (c < 0) ? -c : c;

    // step toward target
    delta = t - c;
    if (delta > s) begin
      nx = c + s;
    end else if (delta < -s) begin
      nx = c - s;
    end else begin
      nx = t;
    end

    in_dz = (nx > -dz) && (nx < dz) && (t > -dz) && (t < dz);

    // start from rest
    if (c == 0 && t > 0) begin
      nx2 = mn;
    end else if (c == 0 && t < 0) begin
      nx2 = -mn;
    end else begin
      nx2 = nx;
    end

    cl = nx2;
    if (cl > mx) begin
      cl = mx;
    end
    if (cl < -mx) begin
      cl = -mx;
    end

    if (in_dz) begin
      res = '0;
    end else if (t == 0 && (c > mn || c < -mn)) begin
      res = '0;
    end else if (t == mn && c > 0 && c < mn) begin
      res = mn;
    end else if (t == -mn && c < 0 && c > -mn) begin
      res = -mn;
    end else if (t == mx && c > 0 && c >= mx - s) begin
      res = mx;
    end else if (t == -mx && c < 0 && c <= -mx + s) begin
      res = -mx;
    end else if (c > mn && t > 0 && t < mn) begin
      res = '0;
    end else if (c < -mn && t < 0 && t > -mn) begin
      res = '0;
    end else if (c > 0 && t < 0 && c < mn) begin
      res = '0;
    end else if (c < 0 && t > 0 && acur < mn) begin
      res = '0;
    end else if (c > 0 && t == 0 && nx2 < mn && nx2 > 0) begin
      res = '0;
    end else if (c < 0 && t == 0 && nx2 > -mn && nx2 < 0) begin
      res = '0;
    end else if (t == 0 && c != 0 && cl == 0 && acur >= brk) begin
      // reverse brake pulse
      res = (c > 0) ? -mn : mn;
    end else begin
      res = cl;
    end

    next_speed = res[SpeedW-1:0];
  end

endmodule

// ----- rtl/motor_speed_slew_limiter.sv -----
// ----------------------------------------------------------------------------
// motor_speed_slew_limiter
// Rate limits a motor speed toward its target with start, snap and brake rules.
//
//   channel  dir  payload                                              width
//   item     in   current_speed, target_speed, deflection_pct, now_ms  11/11/7/32
//   result   out  next_speed, held                                      11/1
//   cfg      in   index, data                                           3/16
//
// one transaction per cycle sustained while the result is taken; an item passes
// the input register, shaping logic and result register in that order
// last_update_time advances as a non-held item moves into the result register
// reset clears valids, last_update_time and restores register defaults
// a stalled result holds its stage; the input stage still fills behind it
// ----------------------------------------------------------------------------
module motor_speed_slew_limiter (
  input  logic        clk,
  input  logic        rst,
  mssl_in_if.sink     item,
  mssl_out_if.source  result,
  mssl_cfg_if.sink    cfg
);
  import mssl_pkg::*;

  cfg_t   regs;
  item_t  s1_item;
  logic   s1_valid;
  logic   out_valid;
  speed_t next_speed;
  logic   held;
  time_t  last_update_time;
  speed_t core_speed;
  logic   core_held;
  logic   s2_load;

  mssl_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  mssl_core u_core (
    .regs             (regs),
    .item             (s1_item),
    .last_update_time (last_update_time),
    .next_speed       (core_speed),
    .held             (core_held)
  );

  assign s2_load    = s1_valid && (!out_valid || result.ready);
  assign item.ready = !s1_valid || s2_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid         <= 1'b0;
      out_valid        <= 1'b0;
      last_update_time <= '0;
    end else begin
      if (item.valid && item.ready) begin
        s1_valid <= 1'b1;
      end else if (s2_load) begin
        s1_valid <= 1'b0;
      end
      if (s2_load) begin
        out_valid <= 1'b1;
        if (!core_held) begin
          last_update_time <= s1_item.now_ms;
        end
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_item.current_speed  <= item.current_speed;
      s1_item.target_speed   <= item.target_speed;
      s1_item.deflection_pct <= item.deflection_pct;
      s1_item.now_ms         <= item.now_ms;
    end
    if (s2_load) begin
      // held transactions pass the present speed through
      next_speed <= core_held ? s1_item.current_speed : core_speed;
      held       <= core_held;
    end
  end

  assign result.valid      = out_valid;
  assign result.next_speed = next_speed;
  assign result.held       = held;

endmodule

// ----- tb/motor_speed_slew_limiter_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// motor_speed_slew_limiter_test
// Self-checking bench for the motor speed slew limiter. Items go in on the
// item channel with random gaps. Each accepted item is run through a
// behavioural model of the ramp, snap, clamp and brake rules and the update
// interval gate. Every result transaction is checked in order against that
// model. The run covers the reset settings, fast mode, all-zero and
// all-ones register values, random settings and a long output stall.
// ----------------------------------------------------------------------------
module motor_speed_slew_limiter_test;
  import mssl_pkg::*;

  localparam int CycleLimit = 300000;
  localparam int ReportMax  = 10;

  typedef struct packed {
    speed_t next_speed;
    logic   held;
  } speed_result_t;

  logic clk = 1'b0;
  logic rst;

  mssl_in_if  item_ch ();
  mssl_out_if result_ch ();
  mssl_cfg_if cfg_ch ();

  motor_speed_slew_limiter DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  // model state
  cfg_t          shadow_cfg;
  time_t         last_update_ms;
  speed_result_t pending_speeds[$];

  // stimulus state
  time_t  now_clock;
  speed_t last_speed;
  speed_t last_target;
  bit     sender_idle_on;
  bit     receiver_idle_on;
  int     hold_off_req;
  int     stall_left;

  int cycle_cnt;
  int error_cnt;
  int items_sent;
  int held_seen;
  int stepped_seen;
  int reg_writes;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               pending_speeds.size());
      $display("FAIL motor_speed_slew_limiter");
      $finish;
    end
  end

  function automatic speed_result_t slew_next(input item_t it);
    speed_result_t res;
    time_t         elapsed;
    int            cur, tgt, defl, step, nxt, acur, mn, mx, dz;
    cur = it.current_speed;
    tgt = it.target_speed;
    defl = it.deflection_pct;
    elapsed = it.now_ms - last_update_ms;
    res.next_speed = it.current_speed;
    res.held = 1'b1;
    if (elapsed < shadow_cfg.update_interval) return res;
    last_update_ms = it.now_ms;
    res.held = 1'b0;
    mn = int'(shadow_cfg.min_speed);
    mx = int'(shadow_cfg.speed_limit);
    dz = int'(shadow_cfg.dead_band);
    step = (defl >= int'(shadow_cfg.deflection_threshold)) ?
           int'(shadow_cfg.ramp_step_fast) : int'(shadow_cfg.ramp_step_lo);
    if (step < 1) step = 1;
    if (tgt - cur > step) nxt = cur + step;
    else if (tgt - cur < -step) nxt = cur - step;
    else nxt = tgt;
    acur = (cur < 0) ? -cur : cur;
    if (nxt > -dz && nxt < dz && tgt > -dz && tgt < dz) begin
      nxt = 0;
    end else begin
      // leaving rest starts at the minimum speed
      if (cur == 0 && tgt > 0) nxt = mn;
      else if (cur == 0 && tgt < 0) nxt = -mn;
      if (tgt == 0 && (cur > mn || cur < -mn)) nxt = 0;
      else if (tgt == mn && cur > 0 && cur < mn) nxt = mn;
      else if (tgt == -mn && cur < 0 && cur > -mn) nxt = -mn;
      else if (tgt == mx && cur > 0 && cur >= mx - step) nxt = mx;
      else if (tgt == -mx && cur < 0 && cur <= -mx + step) nxt = -mx;
      else if ((cur > mn && tgt > 0 && tgt < mn) || (cur < -mn && tgt < 0 && tgt > -mn))
        nxt = 0;
      else if ((cur > 0 && tgt < 0 && cur < mn) || (cur < 0 && tgt > 0 && acur < mn))
        nxt = 0;
      else if ((cur > 0 && tgt == 0 && nxt < mn && nxt > 0) ||
               (cur < 0 && tgt == 0 && nxt > -mn && nxt < 0))
        nxt = 0;
      else begin
        if (nxt > mx) nxt = mx;
        if (nxt < -mx) nxt = -mx;
        // reverse pulse when stopping from high speed
        if (tgt == 0 && cur != 0 && nxt == 0 && acur >= int'(shadow_cfg.brake_threshold))
          nxt = (cur > 0) ? -mn : mn;
      end
    end
    res.next_speed = nxt[SpeedW-1:0];
    return res;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic speed_t around(input int base, input int spread);
    int v;
    v = base + int'($urandom_range(0, 2 * spread)) - spread;
    if ($urandom_range(0, 1) == 1) v = -v;
    return v[SpeedW-1:0];
  endfunction

  function automatic item_t random_item();
    item_t       it;
    int          r, mn, mx, dz, thr;
    int unsigned iv;
    mn = int'(shadow_cfg.min_speed);
    mx = int'(shadow_cfg.speed_limit);
    dz = int'(shadow_cfg.dead_band);
    thr = int'(shadow_cfg.deflection_threshold);
    iv = shadow_cfg.update_interval;
    r = $urandom_range(0, 99);
    if (r < 45) it.current_speed = last_speed;
    else if (r < 55) it.current_speed = '0;
    else if (r < 70) it.current_speed = around(mn, 3);
    else if (r < 80) it.current_speed = around(mx, 3);
    else if (r < 85) it.current_speed = around(0, dz);
    else it.current_speed = speed_t'($urandom);
    r = $urandom_range(0, 99);
    if (r < 55) it.target_speed = last_target;
    else if (r < 63) it.target_speed = '0;
    else if (r < 71) it.target_speed = around(mn, 0);
    else if (r < 79) it.target_speed = around(mx, 0);
    else if (r < 85) it.target_speed = around(0, dz);
    else if (r < 92) it.target_speed = around(int'($urandom_range(0, mx + 20)), 0);
    else it.target_speed = speed_t'($urandom);
    r = $urandom_range(0, 99);
    if (r < 40) it.deflection_pct = pct_t'($urandom_range(0, 100));
    else if (r < 55) it.deflection_pct = pct_t'(thr);
    else if (r < 70) it.deflection_pct = pct_t'(thr - 1);
    else if (r < 85) it.deflection_pct = pct_t'(100);
    else it.deflection_pct = pct_t'($urandom_range(0, 127));
    r = $urandom_range(0, 99);
    if (r < 20 && iv > 0) it.now_ms = now_clock + time_t'($urandom_range(0, iv - 1));
    else if (r < 25) it.now_ms = time_t'($urandom);
    else it.now_ms = now_clock + time_t'(iv) + time_t'($urandom_range(0, 30));
    now_clock = it.now_ms;
    return it;
  endfunction

  task automatic send_item(input item_t it);
    int gap;
    gap = sender_idle_on ? idle_len() : 0;
    if (gap > 0) begin
      @(negedge clk);
      item_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    item_ch.valid = 1'b1;
    item_ch.current_speed = it.current_speed;
    item_ch.target_speed = it.target_speed;
    item_ch.deflection_pct = it.deflection_pct;
    item_ch.now_ms = it.now_ms;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    pending_speeds.push_back(slew_next(it));
    last_speed = pending_speeds[$].next_speed;
    last_target = it.target_speed;
    items_sent++;
  endtask

  task automatic send_speeds(input int cur, input int tgt, input int defl, input int dt);
    item_t it;
    now_clock = now_clock + time_t'(dt);
    it.current_speed = speed_t'(cur);
    it.target_speed = speed_t'(tgt);
    it.deflection_pct = pct_t'(defl);
    it.now_ms = now_clock;
    send_item(it);
  endtask

  task automatic send_random(input int n);
    repeat (n) send_item(random_item());
  endtask

  // wait for every result, then let the pipeline empty
  task automatic settle_idle();
    @(negedge clk);
    item_ch.valid = 1'b0;
    while (pending_speeds.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_settings(input cfg_data_t vals[8]);
    reg_idx_t idx;
    for (int i = 0; i < 8; i++) begin
      idx = reg_idx_t'(i);
      @(negedge clk);
      cfg_ch.valid = 1'b1;
      cfg_ch.index = idx;
      cfg_ch.data = vals[i];
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
      case (idx)
        REG_UPDATE_INTERVAL: shadow_cfg.update_interval = vals[i][IntervW-1:0];
        REG_RAMP_STEP_LO:    shadow_cfg.ramp_step_lo = vals[i][MagW-1:0];
        REG_RAMP_STEP_FAST:  shadow_cfg.ramp_step_fast = vals[i][MagW-1:0];
        REG_DEFL_THRESHOLD:  shadow_cfg.deflection_threshold = vals[i][PctW-1:0];
        REG_MIN_SPEED:       shadow_cfg.min_speed = vals[i][MagW-1:0];
        REG_SPEED_LIMIT:     shadow_cfg.speed_limit = vals[i][MagW-1:0];
        REG_DEAD_BAND:       shadow_cfg.dead_band = vals[i][MagW-1:0];
        REG_BRAKE_THRESHOLD: shadow_cfg.brake_threshold = vals[i][MagW-1:0];
        default: ;
      endcase
      reg_writes++;
    end
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic note_error(input string msg);
    error_cnt++;
    if (error_cnt <= ReportMax) $display("%0t: %s", $realtime, msg);
  endtask

  // result side
  initial begin
    result_ch.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req > 0) begin
        stall_left = hold_off_req;
        hold_off_req = 0;
      end else if (stall_left == 0 && receiver_idle_on && $urandom_range(0, 99) < 30) begin
        stall_left = idle_len();
      end
      if (stall_left > 0) begin
        result_ch.ready = 1'b0;
        stall_left--;
      end else begin
        result_ch.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    speed_result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_speeds.size() == 0) begin
        note_error($sformatf("unexpected result next_speed %0d held %0b",
                             result_ch.next_speed, result_ch.held));
      end else begin
        want = pending_speeds.pop_front();
        if (want.held) held_seen++;
        else stepped_seen++;
        if (result_ch.next_speed !== want.next_speed || result_ch.held !== want.held)
          note_error($sformatf("mismatch: next_speed exp %0d got %0d, held exp %0b got %0b",
                               want.next_speed, result_ch.next_speed, want.held,
                               result_ch.held));
      end
    end
  end

  task automatic test_directed_rules();
    sender_idle_on = 1'b1;
    receiver_idle_on = 1'b1;
    send_speeds(5, 3, 50, 20);
    send_speeds(0, 100, 50, 20);
    send_speeds(0, -100, 50, 20);
    send_speeds(100, 0, 50, 20);
    send_speeds(220, 0, 50, 20);
    send_speeds(-230, 0, 50, 20);
    send_speeds(20, 40, 50, 20);
    send_speeds(-20, -40, 50, 20);
    send_speeds(245, 255, 95, 20);
    send_speeds(-250, -255, 50, 20);
    send_speeds(100, 20, 50, 20);
    send_speeds(-100, -20, 50, 20);
    send_speeds(30, -100, 50, 20);
    send_speeds(-30, 100, 50, 20);
    send_speeds(30, 0, 50, 20);
    send_speeds(-30, 0, 50, 20);
    send_speeds(1023, 1023, 100, 20);
    send_speeds(-1024, -1024, 127, 20);
    send_speeds(100, 200, 0, 20);
    send_speeds(100, 200, 90, 20);
    send_speeds(100, 200, 89, 20);
    send_speeds(100, 200, 50, 3);
    // timestamp wraps through zero
    now_clock = 32'hFFFF_FFF0;
    send_speeds(150, -150, 50, 0);
    send_speeds(150, -150, 50, 25);
    send_speeds(150, -150, 50, 19);
    settle_idle();
  endtask

  task automatic test_fast_mode();
    load_settings('{16'd5, 16'd30, 16'd30, 16'd0, 16'd40, 16'd255, 16'd10, 16'd200});
    sender_idle_on = 1'b0;
    receiver_idle_on = 1'b0;
    send_random(40);
    sender_idle_on = 1'b1;
    receiver_idle_on = 1'b1;
    send_random(40);
    settle_idle();
  endtask

  task automatic test_zero_settings();
    load_settings('{default: '0});
    send_random(50);
    settle_idle();
  endtask

  task automatic test_full_settings();
    load_settings('{default: 16'hFFFF});
    send_random(50);
    settle_idle();
  endtask

  task automatic test_random_settings();
    cfg_data_t vals[8];
    repeat (4) begin
      vals[REG_UPDATE_INTERVAL] = cfg_data_t'($urandom_range(0, 40));
      vals[REG_RAMP_STEP_LO] = cfg_data_t'($urandom_range(0, 20));
      vals[REG_RAMP_STEP_FAST] = cfg_data_t'($urandom_range(0, 200));
      vals[REG_DEFL_THRESHOLD] = cfg_data_t'($urandom_range(0, 100));
      vals[REG_MIN_SPEED] = cfg_data_t'($urandom_range(0, 120));
      vals[REG_SPEED_LIMIT] = cfg_data_t'($urandom_range(0, 1023));
      vals[REG_DEAD_BAND] = cfg_data_t'($urandom_range(0, 60));
      vals[REG_BRAKE_THRESHOLD] = cfg_data_t'($urandom_range(0, 1023));
      load_settings(vals);
      send_random(50);
      settle_idle();
    end
  endtask

  task automatic test_output_backpressure();
    load_settings('{cfg_data_t'(RstUpdateInterval), cfg_data_t'(RstRampStepSlow),
                    cfg_data_t'(RstRampStepFast), cfg_data_t'(RstDeflThreshold),
                    cfg_data_t'(RstMinSpeed), cfg_data_t'(RstMaxSpeed),
                    cfg_data_t'(RstMotorDeadzone), cfg_data_t'(RstBrakeThreshold)});
    sender_idle_on = 1'b0;
    receiver_idle_on = 1'b0;
    @(posedge clk);
    hold_off_req = 80;
    send_random(30);
    sender_idle_on = 1'b1;
    receiver_idle_on = 1'b1;
    send_random(20);
    settle_idle();
  endtask

  initial begin
    rst = 1'b1;
    item_ch.valid = 1'b0;
    item_ch.current_speed = '0;
    item_ch.target_speed = '0;
    item_ch.deflection_pct = '0;
    item_ch.now_ms = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_UPDATE_INTERVAL;
    cfg_ch.data = '0;
    hold_off_req = 0;
    sender_idle_on = 1'b0;
    receiver_idle_on = 1'b0;
    cycle_cnt = 0;
    error_cnt = 0;
    items_sent = 0;
    held_seen = 0;
    stepped_seen = 0;
    reg_writes = 0;
    shadow_cfg = '{update_interval: RstUpdateInterval, ramp_step_lo: RstRampStepSlow,
                   ramp_step_fast: RstRampStepFast, deflection_threshold: RstDeflThreshold,
                   min_speed: RstMinSpeed, speed_limit: RstMaxSpeed,
                   dead_band: RstMotorDeadzone, brake_threshold: RstBrakeThreshold};
    last_update_ms = '0;
    now_clock = '0;
    last_speed = '0;
    last_target = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_rules();
    test_fast_mode();
    test_zero_settings();
    test_full_settings();
    test_random_settings();
    test_output_backpressure();

    receiver_idle_on = 1'b0;
    settle_idle();
    repeat (10) @(posedge clk);
    if (pending_speeds.size() != 0) begin
      error_cnt += pending_speeds.size();
      $display("%0d expected results never arrived", pending_speeds.size());
    end
    $display("%0d items over reset, fast, zero, full, random and stalled-output settings",
             items_sent);
    $display("%0d results held, %0d stepped, %0d register writes, %0d errors",
             held_seen, stepped_seen, reg_writes, error_cnt);
    if (error_cnt == 0) begin
      $display("PASS motor_speed_slew_limiter");
    end else begin
      $display("FAIL motor_speed_slew_limiter");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/mssl_pkg.sv
rtl/mssl_if.sv
rtl/mssl_cfg_regs.sv
rtl/mssl_core.sv
rtl/motor_speed_slew_limiter.sv
tb/motor_speed_slew_limiter_test.sv
